>>> sv/rhc_pkg.sv
// ----------------------------------------------------------------------------
// rhc_pkg: shared types and constants for the rgb to hsv converter
// Channel widths, divider sizing and the payload structs of each stage.
// ----------------------------------------------------------------------------
`default_nettype none

package rhc_pkg;

   // channel and result widths
   localparam int CH_W  = 8;
   localparam int HUE_W = 16;
   localparam int SAT_W = 16;

   // hue resolution as a fraction of a full turn (at most HUE_W bits)
   localparam int HUE_BITS = 16;

   // hue divisor is six times the spread, below 2^11
   localparam int HUE_REM_W = CH_W + 3;
   localparam int SAT_REM_W = CH_W;

   // numerator widths: spread sum shifted up, and 65535 times spread
   localparam int HUE_NUM_W = HUE_REM_W + HUE_BITS;
   localparam int SAT_NUM_W = CH_W + SAT_W;

   // divider: DIV_K quotient bits per pipeline stage
   localparam int DIV_K      = 4;
   localparam int DIV_MAX_W  = (HUE_NUM_W > SAT_NUM_W) ? HUE_NUM_W : SAT_NUM_W;
   localparam int DIV_STAGES = (DIV_MAX_W + DIV_K - 1) / DIV_K;
   localparam int DIV_W      = DIV_STAGES * DIV_K;

   // which channel is largest, and whether red wraps past the top
   typedef enum logic [1:0] {
      SEC_RED,
      SEC_RED_WRAP,
      SEC_GREEN,
      SEC_BLUE
   } sector_type;

   typedef struct packed {
      logic [CH_W-1:0] red;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] blue;
   } pix_type;

   typedef struct packed {
      logic [CH_W-1:0] mx;
      logic [CH_W-1:0] mn;
      logic [CH_W-1:0] pos;
      logic [CH_W-1:0] neg;
      sector_type      sector;
   } sort_type;

   typedef struct packed {
      logic [CH_W-1:0]      value;
      logic                 hue_zero;
      logic                 sat_zero;
      logic [HUE_REM_W-1:0] hue_rem;
      logic [HUE_REM_W-1:0] hue_div;
      logic [DIV_W-1:0]     hue_work;
      logic [SAT_REM_W-1:0] sat_rem;
      logic [SAT_REM_W-1:0] sat_div;
      logic [DIV_W-1:0]     sat_work;
   } div_type;

endpackage

`default_nettype wire

>>> sv/rhc_if.sv
// ----------------------------------------------------------------------------
// rhc_if: pixel and hsv stream channels
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface rhc_pix_if;
   logic       valid;
   logic       ready;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rhc_hsv_if;
   logic        valid;
   logic        ready;
   logic [15:0] hue;
   logic [15:0] saturation;
   logic [7:0]  value;

   modport source (output valid, output hue, output saturation, output value, input ready);
   modport sink   (input valid, input hue, input saturation, input value, output ready);
endinterface

`default_nettype wire

>>> sv/rhc_sort.sv
// ----------------------------------------------------------------------------
// rhc_sort: channel ordering stage
// Finds largest and smallest channel and picks the hue sector.
// ----------------------------------------------------------------------------
`default_nettype none

module rhc_sort (
   input  logic             clock,
   input  logic             reset,
   input  logic             up_valid,
   input  rhc_pkg::pix_type up_data,
   output logic             up_ready,
   output logic             dn_valid,
   output rhc_pkg::sort_type dn_data,
   input  logic             dn_ready
);
   import rhc_pkg::*;

   logic     valid_ff, valid_in;
   sort_type data_ff, data_in;
   sort_type sort_c;

   // largest channel, ties go red then green
   always_comb begin
      logic [CH_W-1:0] r, g, b;
      r = up_data.red;
      g = up_data.green;
      b = up_data.blue;
      sort_c.mn = (r < g) ? ((r < b) ? r : b) : ((g < b) ? g : b);
      if (r >= g && r >= b) begin
         sort_c.mx     = r;
         sort_c.pos    = g;
         sort_c.neg    = b;
         sort_c.sector = (g >= b) ? SEC_RED : SEC_RED_WRAP;
      end else if (g >= b) begin
         sort_c.mx     = g;
         sort_c.pos    = b;
         sort_c.neg    = r;
         sort_c.sector = SEC_GREEN;
      end else begin
         sort_c.mx     = b;
         sort_c.pos    = r;
         sort_c.neg    = g;
         sort_c.sector = SEC_BLUE;
      end
   end

   // stage handshake, bubbles collapse
   assign up_ready = !valid_ff || dn_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;
   assign data_in  = (up_ready && up_valid) ? sort_c : data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

`default_nettype wire

>>> sv/rhc_setup.sv
// ----------------------------------------------------------------------------
// rhc_setup: divider operand stage
// Forms spread, hue numerator and divisor, and the saturation numerator.
// ----------------------------------------------------------------------------
`default_nettype none

module rhc_setup (
   input  logic              clock,
   input  logic              reset,
   input  logic              up_valid,
   input  rhc_pkg::sort_type up_data,
   output logic              up_ready,
   output logic              dn_valid,
   output rhc_pkg::div_type  dn_data,
   input  logic              dn_ready
);
   import rhc_pkg::*;

   logic    valid_ff, valid_in;
   div_type data_ff, data_in;
   div_type setup_c;

   // operands for both dividers
   always_comb begin
      logic [CH_W-1:0]      d;
      logic [HUE_REM_W-1:0] d6, off_d, num;
      logic [SAT_NUM_W-1:0] sat_num;
      d  = up_data.mx - up_data.mn;
      d6 = {1'b0, d, 2'b00} + {2'b00, d, 1'b0};
      case (up_data.sector)
         SEC_RED:      off_d = '0;
         SEC_RED_WRAP: off_d = d6;
         SEC_GREEN:    off_d = {2'b00, d, 1'b0};
         SEC_BLUE:     off_d = {1'b0, d, 2'b00};
         default:      off_d = '0;
      endcase
      // true sum lies in 0 .. 6d-1, so modular width is exact
      num     = off_d + HUE_REM_W'(up_data.pos) - HUE_REM_W'(up_data.neg);
      sat_num = {d, {SAT_W{1'b0}}} - SAT_NUM_W'(d);

      setup_c.value    = up_data.mx;
      setup_c.hue_zero = (d == '0);
      setup_c.sat_zero = (up_data.mx == '0);
      setup_c.hue_rem  = '0;
      setup_c.hue_div  = d6;
      setup_c.hue_work = DIV_W'(num) << HUE_BITS;
      setup_c.sat_rem  = '0;
      setup_c.sat_div  = up_data.mx;
      setup_c.sat_work = DIV_W'(sat_num);
   end

   // stage handshake
   assign up_ready = !valid_ff || dn_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;
   assign data_in  = (up_ready && up_valid) ? setup_c : data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

`default_nettype wire

>>> sv/rhc_div_stage.sv
// ----------------------------------------------------------------------------
// rhc_div_stage: one slice of the restoring dividers
// Retires DIV_K quotient bits of both the hue and saturation division.
// ----------------------------------------------------------------------------
`default_nettype none

module rhc_div_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             up_valid,
   input  rhc_pkg::div_type up_data,
   output logic             up_ready,
   output logic             dn_valid,
   output rhc_pkg::div_type dn_data,
   input  logic             dn_ready
);
   import rhc_pkg::*;

   logic    valid_ff, valid_in;
   div_type data_ff, data_in;
   div_type step_c;

   // numerator shifts out the top while quotient bits shift in below
   always_comb begin
      logic [HUE_REM_W:0] hue_trial;
      logic [SAT_REM_W:0] sat_trial;
      logic               hue_bit, sat_bit;
      step_c = up_data;
      for (int k = 0; k < DIV_K; k++) begin
         hue_trial = {step_c.hue_rem, step_c.hue_work[DIV_W-1]};
         hue_bit   = (hue_trial >= {1'b0, step_c.hue_div});
         if (hue_bit) begin
            step_c.hue_rem = HUE_REM_W'(hue_trial - {1'b0, step_c.hue_div});
         end else begin
            step_c.hue_rem = hue_trial[HUE_REM_W-1:0];
         end
         step_c.hue_work = {step_c.hue_work[DIV_W-2:0], hue_bit};

         sat_trial = {step_c.sat_rem, step_c.sat_work[DIV_W-1]};
         sat_bit   = (sat_trial >= {1'b0, step_c.sat_div});
         if (sat_bit) begin
            step_c.sat_rem = SAT_REM_W'(sat_trial - {1'b0, step_c.sat_div});
         end else begin
            step_c.sat_rem = sat_trial[SAT_REM_W-1:0];
         end
         step_c.sat_work = {step_c.sat_work[DIV_W-2:0], sat_bit};
      end
   end

   // stage handshake
   assign up_ready = !valid_ff || dn_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;
   assign data_in  = (up_ready && up_valid) ? step_c : data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

`default_nettype wire

>>> sv/rgb_to_hsv_converter_core.sv
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter_core: pipelined rgb to hsv pixel converter
// Converts 8-bit rgb pixels to hue, saturation and value at one per clock when rsp does not stall.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one pixel per beat (red, green, blue); rsp returns one
//   hue/saturation/value beat per pixel, in order.
//   Value is the largest channel, saturation is 65535*spread/value floored,
//   hue is the wheel position as a fraction of a turn times 2^HUE_BITS.
//   An accepted pixel passes the sort, setup, divider slice and output
//   registers before rsp valid. The depth is set by the two
//   restoring dividers, which retire DIV_K quotient bits per stage.
//   Throughput is one pixel per clock, and a new pixel can enter every cycle, while rsp takes beats.
//   Each stage holds its beat while the next one is full and stalled, so a
//   stall on rsp backs up stage by stage; empty stages still take new
//   pixels, and nothing is dropped or repeated.
//   Synchronous reset empties the pipeline; no state survives a pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_to_hsv_converter_core (
   input  logic      clock,
   input  logic      reset,
   rhc_pix_if.sink   req,
   rhc_hsv_if.source rsp
);
   import rhc_pkg::*;

   pix_type  pix_c;
   sort_type sort_data;
   logic     sort_valid, sort_ready;

   div_type  div_data  [DIV_STAGES+1];
   logic     div_valid [DIV_STAGES+1];
   logic     div_ready [DIV_STAGES+1];

   logic              out_valid_ff, out_valid_in;
   logic [HUE_W-1:0]  hue_ff, hue_in;
   logic [SAT_W-1:0]  sat_ff, sat_in;
   logic [CH_W-1:0]   value_ff, value_in;
   logic              out_ready;

   assign pix_c.red   = req.red;
   assign pix_c.green = req.green;
   assign pix_c.blue  = req.blue;

   // channel ordering and sector pick
   rhc_sort u_sort (
      .clock    (clock),
      .reset    (reset),
      .up_valid (req.valid),
      .up_data  (pix_c),
      .up_ready (req.ready),
      .dn_valid (sort_valid),
      .dn_data  (sort_data),
      .dn_ready (sort_ready)
   );

   // divider operands
   rhc_setup u_setup (
      .clock    (clock),
      .reset    (reset),
      .up_valid (sort_valid),
      .up_data  (sort_data),
      .up_ready (sort_ready),
      .dn_valid (div_valid[0]),
      .dn_data  (div_data[0]),
      .dn_ready (div_ready[0])
   );

   // divider slices
   for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
      rhc_div_stage u_div (
         .clock    (clock),
         .reset    (reset),
         .up_valid (div_valid[i]),
         .up_data  (div_data[i]),
         .up_ready (div_ready[i]),
         .dn_valid (div_valid[i+1]),
         .dn_data  (div_data[i+1]),
         .dn_ready (div_ready[i+1])
      );
   end

   // output register, hue of grey and saturation of black pixels forced to zero
   assign out_ready                = !out_valid_ff || rsp.ready;
   assign div_ready[DIV_STAGES]    = out_ready;
   assign out_valid_in = out_ready ? div_valid[DIV_STAGES] : out_valid_ff;

   always_comb begin
      hue_in   = hue_ff;
      sat_in   = sat_ff;
      value_in = value_ff;
      if (out_ready && div_valid[DIV_STAGES]) begin
         hue_in   = div_data[DIV_STAGES].hue_zero ? '0
                                                  : div_data[DIV_STAGES].hue_work[HUE_W-1:0];
         sat_in   = div_data[DIV_STAGES].sat_zero ? '0
                                                  : div_data[DIV_STAGES].sat_work[SAT_W-1:0];
         value_in = div_data[DIV_STAGES].value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hue_ff   <= hue_in;
      sat_ff   <= sat_in;
      value_ff <= value_in;
   end

   assign rsp.valid      = out_valid_ff;
   assign rsp.hue        = hue_ff;
   assign rsp.saturation = sat_ff;
   assign rsp.value      = value_ff;

endmodule

`default_nettype wire

>>> verif/rgb_to_hsv_converter_core_checker.sv
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter_core_checker: hsv prediction and compare
// Watches the pixel and hsv channels, predicts hue, saturation and value
// for every accepted pixel beat, and compares rsp beats in order.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_to_hsv_converter_core_checker (
   input  logic clock,
   input  logic reset,
   rhc_pix_if   pix,
   rhc_hsv_if   hsv,
   output int   mismatch_count,
   output int   pending_count
);

   typedef struct packed {
      logic [15:0] hue;
      logic [15:0] saturation;
      logic [7:0]  value;
   } hsv_type;

   hsv_type hsv_expected [$];

   // one line per mismatch, and count it
   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   // exact integer hsv of one pixel
   function automatic hsv_type predict_hsv(input logic [7:0] r, g, b);
      longint unsigned red_c, green_c, blue_c;
      longint unsigned top, bottom, spread, wheel;
      hsv_type result;
      red_c   = r;
      green_c = g;
      blue_c  = b;
      top     = red_c;
      if (green_c > top) top = green_c;
      if (blue_c > top) top = blue_c;
      bottom  = red_c;
      if (green_c < bottom) bottom = green_c;
      if (blue_c < bottom) bottom = blue_c;
      spread  = top - bottom;
      result  = '0;
      result.value = top[7:0];
      if (top != 0) begin
         result.saturation = 16'((65535 * spread) / top);
      end
      // sector order: red, then green, then blue as largest
      if (spread != 0) begin
         if (top == red_c) begin
            if (green_c >= blue_c) wheel = green_c - blue_c;
            else wheel = 6 * spread + green_c - blue_c;
         end else if (top == green_c) begin
            wheel = 2 * spread + blue_c - red_c;
         end else begin
            wheel = 4 * spread + red_c - green_c;
         end
         result.hue = 16'((wheel << rhc_pkg::HUE_BITS) / (6 * spread));
      end
      return result;
   endfunction

   // compare rsp beats first, then queue the prediction for a new pixel
   always @(posedge clock) begin
      hsv_type want;
      if (reset) begin
         hsv_expected.delete();
         mismatch_count = 0;
      end else begin
         if (hsv.valid && hsv.ready) begin
            if (hsv_expected.size() == 0) begin
               report_mismatch($sformatf("rsp beat with no pixel pending: h=%h s=%h v=%h",
                                         hsv.hue, hsv.saturation, hsv.value));
            end else begin
               want = hsv_expected.pop_front();
               if (hsv.hue !== want.hue)
                  report_mismatch($sformatf("hue got %h want %h", hsv.hue, want.hue));
               if (hsv.saturation !== want.saturation)
                  report_mismatch($sformatf("saturation got %h want %h",
                                            hsv.saturation, want.saturation));
               if (hsv.value !== want.value)
                  report_mismatch($sformatf("value got %h want %h", hsv.value, want.value));
            end
         end
         if (pix.valid && pix.ready) begin
            hsv_expected.push_back(predict_hsv(pix.red, pix.green, pix.blue));
         end
      end
      pending_count <= hsv_expected.size();
   end

endmodule

`default_nettype wire

>>> verif/rgb_to_hsv_converter_core_tb.sv
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter_core_tb: testbench top for the rgb to hsv converter
// Drives corner pixels and then random pixels under three backpressure
// mixes; the checker predicts and compares every hsv beat.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_to_hsv_converter_core_tb;

   localparam int LATENCY     = rhc_pkg::DIV_STAGES + 3;
   localparam int RANDOM_BEATS = 500;

   logic clock = 1'b0;
   logic reset;
   int   send_idle_pct;
   int   recv_idle_pct;
   int   mismatch_count;
   int   pending_count;

   rhc_pix_if pix_bus ();
   rhc_hsv_if hsv_bus ();

   rgb_to_hsv_converter_core DUT (
      .clock (clock),
      .reset (reset),
      .req   (pix_bus.sink),
      .rsp   (hsv_bus.source)
   );

   rgb_to_hsv_converter_core_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .pix            (pix_bus),
      .hsv            (hsv_bus),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   // clock, period 4
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // receiver backpressure
   always @(posedge clock) begin
      if (reset) begin
         hsv_bus.ready <= 1'b0;
      end else begin
         hsv_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // hard stop
   initial begin
      #2000000;
      $display("FAILURE");
      $finish;
   end

   // one pixel beat, with a random gap ahead of it
   task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
      if ($urandom_range(99) < send_idle_pct) begin
         pix_bus.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      pix_bus.valid <= 1'b1;
      pix_bus.red   <= r;
      pix_bus.green <= g;
      pix_bus.blue  <= b;
      do @(posedge clock); while (!pix_bus.ready);
   endtask

   // random pixel, weighted toward greys, ties, full scale, zero channels and tiny spreads
   task automatic send_random_pixel();
      logic [7:0] r, g, b, top;
      r   = 8'($urandom);
      g   = 8'($urandom);
      b   = 8'($urandom);
      top = 8'($urandom);
      case ($urandom_range(9))
         0: begin
            g = r;
            b = r;
         end
         1: begin
            r = top;
            g = top;
            b = 8'($urandom_range(top));
         end
         2: begin
            g = top;
            b = top;
            r = 8'($urandom_range(top));
         end
         3: begin
            r = top;
            b = top;
            g = 8'($urandom_range(top));
         end
         4: begin
            case ($urandom_range(2))
               0: r = 8'hff;
               1: g = 8'hff;
               default: b = 8'hff;
            endcase
         end
         5: begin
            g = r + 8'($urandom_range(2)) - 8'd1;
            b = r + 8'($urandom_range(2)) - 8'd1;
         end
         6: begin
            case ($urandom_range(2))
               0: r = 8'h00;
               1: g = 8'h00;
               default: b = 8'h00;
            endcase
         end
         default: ;
      endcase
      send_pixel(r, g, b);
   endtask

   // stimulus and verdict
   initial begin
      reset         = 1'b1;
      pix_bus.valid = 1'b0;
      pix_bus.red   = '0;
      pix_bus.green = '0;
      pix_bus.blue  = '0;
      send_idle_pct = 38;
      recv_idle_pct = 77;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // black, white, grey and the primaries and secondaries
      send_pixel(8'd0,   8'd0,   8'd0);
      send_pixel(8'd255, 8'd255, 8'd255);
      send_pixel(8'd128, 8'd128, 8'd128);
      send_pixel(8'd1,   8'd1,   8'd1);
      send_pixel(8'd255, 8'd0,   8'd0);
      send_pixel(8'd0,   8'd255, 8'd0);
      send_pixel(8'd0,   8'd0,   8'd255);
      send_pixel(8'd255, 8'd255, 8'd0);
      send_pixel(8'd0,   8'd255, 8'd255);
      send_pixel(8'd255, 8'd0,   8'd255);
      // red largest with green below blue wraps past the top of the wheel
      send_pixel(8'd255, 8'd0,   8'd1);
      send_pixel(8'd255, 8'd1,   8'd0);
      send_pixel(8'd255, 8'd0,   8'd254);
      // smallest nonzero spreads
      send_pixel(8'd1,   8'd0,   8'd0);
      send_pixel(8'd0,   8'd1,   8'd0);
      send_pixel(8'd0,   8'd0,   8'd1);
      send_pixel(8'd255, 8'd254, 8'd254);
      send_pixel(8'd254, 8'd255, 8'd255);
      // ties for the largest channel, then two pixels without a tie
      send_pixel(8'd200, 8'd200, 8'd100);
      send_pixel(8'd100, 8'd200, 8'd200);
      send_pixel(8'd200, 8'd100, 8'd200);
      send_pixel(8'd1,   8'd1,   8'd0);
      send_pixel(8'd170, 8'd85,  8'd0);
      send_pixel(8'd85,  8'd0,   8'd255);

      for (int i = 0; i < RANDOM_BEATS; i++) send_random_pixel();
      send_idle_pct = 77;
      recv_idle_pct = 38;
      for (int i = 0; i < RANDOM_BEATS; i++) send_random_pixel();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      for (int i = 0; i < RANDOM_BEATS; i++) send_random_pixel();
      pix_bus.valid <= 1'b0;

      // drain, then a quiet window to catch stray beats
      while (pending_count != 0) @(posedge clock);
      repeat (4 * LATENCY) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

`default_nettype wire

>>> rgb_to_hsv_converter_core.f
sv/rhc_pkg.sv
sv/rhc_if.sv
sv/rhc_sort.sv
sv/rhc_setup.sv
sv/rhc_div_stage.sv
sv/rgb_to_hsv_converter_core.sv
verif/rgb_to_hsv_converter_core_checker.sv
verif/rgb_to_hsv_converter_core_tb.sv
